// ===== hdl/pfbq_pkg.sv =====
package pfbq_pkg;

    localparam int TAG_PORT_W = 16;
    localparam int CAP_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== hdl/pfbq_cell.sv =====
module pfbq_cell #(
    parameter int TAG_WIDTH = 16
) (
    input  logic                    clk,
    input  pfbq_pkg::cell_ctrl_t    ctrl,
    input  logic                    at_tail,
    input  logic [TAG_WIDTH-1:0]    new_tag,
    input  logic [TAG_WIDTH-1:0]    prev_tag,
    input  logic [TAG_WIDTH-1:0]    next_tag,
    output logic [TAG_WIDTH-1:0]    tag
);

    logic [TAG_WIDTH-1:0] tag_reg;
    logic [TAG_WIDTH-1:0] tag_next;

    always_comb
    begin
        tag_next = tag_reg;
        if (ctrl.push_front)
        begin
            tag_next = prev_tag;
        end
        else if (ctrl.push_back && at_tail)
        begin
            tag_next = new_tag;
        end
        else if (ctrl.pop)
        begin
            tag_next = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag = tag_reg;

endmodule

// ===== hdl/priority_front_bounded_queue.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     action, entry_tag, to_front
// out      output     out_valid / out_ready   served_tag, status, occupancy
// cfg      input      cfg_we                  cfg_wdata (capacity)
//
// One item per cycle unless the output stalls; each result appears in the cycle
// after its item is taken. Entries sit in a row of cells ordered head first; a
// successful operation shifts the row by one place or loads the cell at the tail.
// Reset clears count, output valid and sets capacity to 16; cells hold junk.
// A stalled output blocks the input only while the output register is full.
module priority_front_bounded_queue #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [pfbq_pkg::TAG_PORT_W-1:0]     entry_tag,
    input  logic                                to_front,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pfbq_pkg::TAG_PORT_W-1:0]     served_tag,
    output logic [pfbq_pkg::STATUS_W-1:0]       status,
    output logic [pfbq_pkg::OCC_W-1:0]          occupancy,
    input  logic                                cfg_we,
    input  logic [pfbq_pkg::CAP_W-1:0]          cfg_wdata
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > pfbq_pkg::CAP_W) ? CW : pfbq_pkg::CAP_W;
    localparam int PW    = pfbq_pkg::TAG_PORT_W;
    localparam int OW    = pfbq_pkg::OCC_W;

    logic [pfbq_pkg::CAP_W-1:0]    capacity_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          out_valid_reg;
    logic [PW-1:0]                 served_reg;
    logic [PW-1:0]                 served_next;
    logic [pfbq_pkg::STATUS_W-1:0] status_reg;
    logic [pfbq_pkg::STATUS_W-1:0] status_next;

    logic                   take;
    logic                   is_full;
    logic                   is_empty;
    pfbq_pkg::cell_ctrl_t   ctrl;
    logic [TAG_WIDTH-1:0]   new_tag;
    logic [TAG_WIDTH-1:0]   cell_tag [DEPTH];
    logic [PW-1:0]          head_tag;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign is_full  = (count_reg >= CW'(DEPTH))
                   || (CMP_W'(count_reg) >= CMP_W'(capacity_reg));
    assign is_empty = (count_reg == '0);

    generate
        if (TAG_WIDTH >= PW)
        begin : g_wide
            assign new_tag  = TAG_WIDTH'(entry_tag);
            assign head_tag = cell_tag[0][PW-1:0];
        end
        else
        begin : g_narrow
            assign new_tag  = entry_tag[TAG_WIDTH-1:0];
            assign head_tag = PW'(cell_tag[0]);
        end
    endgenerate

    always_comb
    begin
        ctrl.push_front = take && (action == pfbq_pkg::ACT_ENQUEUE) && !is_full && to_front;
        ctrl.push_back  = take && (action == pfbq_pkg::ACT_ENQUEUE) && !is_full && !to_front;
        ctrl.pop        = take && (action == pfbq_pkg::ACT_DEQUEUE) && !is_empty;
    end

    always_comb
    begin
        count_next  = count_reg;
        served_next = '0;
        status_next = pfbq_pkg::ST_DONE;
        case (action)
            pfbq_pkg::ACT_ENQUEUE:
            begin
                if (is_full)
                begin
                    status_next = pfbq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            pfbq_pkg::ACT_DEQUEUE:
            begin
                if (is_empty)
                begin
                    status_next = pfbq_pkg::ST_EMPTY;
                end
                else
                begin
                    served_next = head_tag;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [TAG_WIDTH-1:0] prev_tag;
            logic [TAG_WIDTH-1:0] next_tag;

            if (i == 0)
            begin : g_first
                assign prev_tag = new_tag;
            end
            else
            begin : g_mid
                assign prev_tag = cell_tag[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign next_tag = cell_tag[i];
            end
            else
            begin : g_body
                assign next_tag = cell_tag[i+1];
            end

            pfbq_cell #(
                .TAG_WIDTH (TAG_WIDTH)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .at_tail  (count_reg == CW'(i)),
                .new_tag  (new_tag),
                .prev_tag (prev_tag),
                .next_tag (next_tag),
                .tag      (cell_tag[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= pfbq_pkg::CAPACITY_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (take)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            served_reg <= served_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign served_tag = served_reg;
    assign status     = status_reg;
    assign occupancy  = OW'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        take && (action == pfbq_pkg::ACT_DEQUEUE) && (count_reg == '0)
        |=> out_valid && (status == pfbq_pkg::ST_EMPTY) && (count_reg == '0))
        else $error("dequeue on empty not reported");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        take && (action == pfbq_pkg::ACT_ENQUEUE) && (count_reg >= CW'(DEPTH))
        |=> (status == pfbq_pkg::ST_FULL) && $stable(count_reg))
        else $error("enqueue past depth not refused");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pfbq_pkg::ST_DONE) |-> (served_tag == '0))
        else $error("refused item carries a tag");

endmodule
